// File: sv/ptd_pkg.sv
package ptd_pkg;

  localparam int OFFSET_BITS_DEF   = 24;
  localparam int MAX_CODE_BITS_DEF = 32;

  localparam logic [23:0] START_PREFIX = 24'h000001;
  localparam logic [4:0]  NAL_SLICE    = 5'd1;
  localparam logic [4:0]  NAL_IDR      = 5'd5;

  localparam logic [2:0] PIC_IDR     = 3'd0;
  localparam logic [2:0] PIC_I       = 3'd1;
  localparam logic [2:0] PIC_P       = 3'd2;
  localparam logic [2:0] PIC_B       = 3'd3;
  localparam logic [2:0] PIC_UNKNOWN = 3'd4;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_PREFIX = 4'b0010,
    PH_SUFFIX = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  picture_type;
    logic [4:0]  nal_kind;
    logic [3:0]  slice_kind;
    logic [15:0] first_macroblock;
    logic [23:0] slice_offset;
  } out_beat_t;

  // slice_kind is already saturated, so codes three, four and above seven fall to unknown
  function automatic logic [2:0] classify(input logic [3:0] sk, input logic [4:0] nal);
    logic [2:0] pt;
    case (sk)
      4'd0, 4'd5: pt = PIC_P;
      4'd1, 4'd6: pt = PIC_B;
      4'd2, 4'd7: pt = (nal == NAL_IDR) ? PIC_IDR : PIC_I;
      default:    pt = PIC_UNKNOWN;
    endcase
    return pt;
  endfunction

endpackage

// File: sv/ptd_beat_if.sv
interface ptd_beat_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/h264_picture_type_detector.sv
// channel   dir  payload
// bytes     in   data_byte[7:0], frame_end
// result    out  found, picture_type[2:0], nal_kind[4:0], slice_kind[3:0],
//                first_macroblock[15:0], slice_offset[23:0]
//
// one byte per cycle while the result register is not stalled; a byte is registered
// in the input stage, then decoded (all eight exp-golomb bits of the byte in one
// pass) into the result register
// synchronous reset clears both stages and all parse state
// a stalled result register holds the input stage; bytes flow again as soon as it drains
module h264_picture_type_detector
  import ptd_pkg::*;
#(
  parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ptd_beat_if.sink   bytes,
  ptd_beat_if.source result
);

  logic                     s1_valid;
  in_beat_t                 s1;
  logic                     advance;

  logic [23:0]              byte_history;
  logic [OFFSET_BITS-1:0]   byte_position;
  phase_t                   phase;
  logic [5:0]               zero_count;
  logic [MAX_CODE_BITS-1:0] suffix_accum;
  logic                     code_index;
  logic [15:0]              held_first_mb;
  logic [4:0]               held_nal_kind;
  logic [OFFSET_BITS-1:0]   held_offset;

  logic [23:0]              byte_history_next;
  logic [OFFSET_BITS-1:0]   byte_position_next;
  phase_t                   phase_next;
  logic [5:0]               zero_count_next;
  logic [MAX_CODE_BITS-1:0] suffix_accum_next;
  logic                     code_index_next;
  logic [15:0]              held_first_mb_next;
  logic [4:0]               held_nal_kind_next;
  logic [OFFSET_BITS-1:0]   held_offset_next;

  logic                     hit;
  logic [MAX_CODE_BITS-1:0] code_val;
  logic [3:0]               sk;
  logic [31:0]              off_wide;

  logic                     result_valid;
  out_beat_t                result_beat;

  assign advance     = !result_valid || result.ready;
  assign bytes.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (bytes.valid && bytes.ready) begin
      s1 <= bytes.payload;
    end
  end

  always_comb begin
    logic       done;
    logic       bitv;
    logic [4:0] kind;
    byte_history_next  = byte_history;
    phase_next         = phase;
    zero_count_next    = zero_count;
    suffix_accum_next  = suffix_accum;
    code_index_next    = code_index;
    held_first_mb_next = held_first_mb;
    held_nal_kind_next = held_nal_kind;
    held_offset_next   = held_offset;
    hit                = 1'b0;
    code_val           = '0;
    done               = 1'b0;
    bitv               = 1'b0;
    kind               = s1.data_byte[4:0];
    byte_position_next = (byte_position == '1) ? byte_position : byte_position + 1'b1;

    if (phase == PH_SEARCH) begin
      if (byte_history == START_PREFIX) begin
        byte_history_next = '1;
        if (kind == NAL_SLICE || kind == NAL_IDR) begin
          held_nal_kind_next = kind;
          held_offset_next   = byte_position_next;
          phase_next         = PH_PREFIX;
          zero_count_next    = '0;
          code_index_next    = 1'b0;
          suffix_accum_next  = '0;
        end
      end else begin
        byte_history_next = {byte_history[15:0], s1.data_byte};
      end
    end else if (phase == PH_PREFIX || phase == PH_SUFFIX) begin
      for (int i = 7; i >= 0; i--) begin
        done = 1'b0;
        bitv = s1.data_byte[3'(i)];
        if (phase_next == PH_PREFIX) begin
          if (!bitv) begin
            if (zero_count_next != '1) begin
              zero_count_next = zero_count_next + 1'b1;
            end
          end else begin
            suffix_accum_next = MAX_CODE_BITS'(1);
            if (zero_count_next == '0) begin
              done = 1'b1;
            end else begin
              phase_next = PH_SUFFIX;
            end
          end
        end else if (phase_next == PH_SUFFIX) begin
          if (suffix_accum_next[MAX_CODE_BITS-1]) begin
            suffix_accum_next = '1;
          end else begin
            suffix_accum_next = {suffix_accum_next[MAX_CODE_BITS-2:0], bitv};
          end
          zero_count_next = zero_count_next - 1'b1;
          if (zero_count_next == '0) begin
            done = 1'b1;
          end
        end
        if (done) begin
          if (!code_index_next) begin
            held_first_mb_next = ((suffix_accum_next - 1'b1) > MAX_CODE_BITS'(16'hFFFF))
                                 ? 16'hFFFF : 16'(suffix_accum_next - 1'b1);
            code_index_next    = 1'b1;
            zero_count_next    = '0;
            suffix_accum_next  = '0;
            phase_next         = PH_PREFIX;
          end else begin
            code_val   = suffix_accum_next - 1'b1;
            hit        = 1'b1;
            phase_next = PH_DONE;
          end
        end
      end
    end
  end

  assign sk       = (code_val > MAX_CODE_BITS'(15)) ? 4'd15 : code_val[3:0];
  assign off_wide = 32'(held_offset_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_history  <= '1;
      byte_position <= '0;
      phase         <= PH_SEARCH;
      zero_count    <= '0;
      suffix_accum  <= '0;
      code_index    <= 1'b0;
      held_first_mb <= '0;
      held_nal_kind <= '0;
      held_offset   <= '0;
      result_valid  <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b0;
      if (s1_valid) begin
        if (hit) begin
          result_valid                 <= 1'b1;
          result_beat.found            <= 1'b1;
          result_beat.picture_type     <= classify(sk, held_nal_kind_next);
          result_beat.nal_kind         <= held_nal_kind_next;
          result_beat.slice_kind       <= sk;
          result_beat.first_macroblock <= held_first_mb_next;
          result_beat.slice_offset     <= off_wide[23:0];
        end else if (s1.frame_end && phase_next != PH_DONE) begin
          result_valid                 <= 1'b1;
          result_beat.found            <= 1'b0;
          result_beat.picture_type     <= PIC_UNKNOWN;
          result_beat.nal_kind         <= '0;
          result_beat.slice_kind       <= '0;
          result_beat.first_macroblock <= '0;
          result_beat.slice_offset     <= '0;
        end
        if (s1.frame_end) begin
          byte_history  <= '1;
          byte_position <= '0;
          phase         <= PH_SEARCH;
          zero_count    <= '0;
          suffix_accum  <= '0;
          code_index    <= 1'b0;
          held_first_mb <= '0;
          held_nal_kind <= '0;
          held_offset   <= '0;
        end else begin
          byte_history  <= byte_history_next;
          byte_position <= byte_position_next;
          phase         <= phase_next;
          zero_count    <= zero_count_next;
          suffix_accum  <= suffix_accum_next;
          code_index    <= code_index_next;
          held_first_mb <= held_first_mb_next;
          held_nal_kind <= held_nal_kind_next;
          held_offset   <= held_offset_next;
        end
      end
    end
  end

  assign result.valid   = result_valid;
  assign result.payload = result_beat;

endmodule

// File: tb/h264_picture_type_detector_test.sv
`timescale 1ns / 100ps

module h264_picture_type_detector_test;
  import ptd_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int BYTES_PER_PHASE = 200;

  class picture_type_scoreboard;
    logic [23:0] history;
    logic [23:0] position;
    phase_t      scan_phase;
    logic [5:0]  zero_count;
    logic [31:0] accum;
    logic        second_code;
    logic [15:0] held_first_mb;
    logic [4:0]  held_nal;
    logic [23:0] held_offset;
    out_beat_t   expected_reports[$];
    int          failures;

    function new();
      failures = 0;
      clear();
    endfunction

    function void clear();
      history = '1;
      position = '0;
      scan_phase = PH_SEARCH;
      zero_count = '0;
      accum = '0;
      second_code = 1'b0;
      held_first_mb = '0;
      held_nal = '0;
      held_offset = '0;
    endfunction

    function logic [2:0] picture_of(logic [31:0] st, logic [4:0] nal);
      if (st > 9) return PIC_UNKNOWN;
      case (st % 5)
        0: return PIC_P;
        1: return PIC_B;
        2: return (nal == NAL_IDR) ? PIC_IDR : PIC_I;
        default: return PIC_UNKNOWN;
      endcase
    endfunction

    function void note_byte(in_beat_t beat);
      out_beat_t   rpt;
      logic        bit_v;
      logic        done;
      logic        emitted;
      logic [31:0] val;
      rpt = '0;
      emitted = 1'b0;
      if (scan_phase == PH_SEARCH) begin
        if (history == START_PREFIX) begin
          // header byte never counts towards the next start code
          history = '1;
          if (beat.data_byte[4:0] == NAL_SLICE || beat.data_byte[4:0] == NAL_IDR) begin
            held_nal = beat.data_byte[4:0];
            held_offset = (position == '1) ? position : position + 24'd1;
            scan_phase = PH_PREFIX;
            zero_count = '0;
            second_code = 1'b0;
            accum = '0;
          end
        end else begin
          history = {history[15:0], beat.data_byte};
        end
      end else if (scan_phase != PH_DONE) begin
        for (int b = 7; b >= 0; b--) begin
          if (scan_phase == PH_PREFIX || scan_phase == PH_SUFFIX) begin
            bit_v = beat.data_byte[b];
            done = 1'b0;
            if (scan_phase == PH_PREFIX) begin
              if (!bit_v) begin
                if (zero_count != 6'd63) zero_count++;
              end else begin
                accum = 32'd1;
                if (zero_count == 0) done = 1'b1;
                else scan_phase = PH_SUFFIX;
              end
            end else begin
              if (accum[31]) accum = '1;
              else accum = {accum[30:0], bit_v};
              zero_count--;
              if (zero_count == 0) done = 1'b1;
            end
            if (done) begin
              val = accum - 1;
              if (!second_code) begin
                held_first_mb = (val > 32'hFFFF) ? 16'hFFFF : val[15:0];
                second_code = 1'b1;
                zero_count = '0;
                accum = '0;
                scan_phase = PH_PREFIX;
              end else begin
                rpt.found = 1'b1;
                rpt.picture_type = picture_of(val, held_nal);
                rpt.nal_kind = held_nal;
                rpt.slice_kind = (val > 15) ? 4'hF : val[3:0];
                rpt.first_macroblock = held_first_mb;
                rpt.slice_offset = held_offset;
                emitted = 1'b1;
                scan_phase = PH_DONE;
              end
            end
          end
        end
      end
      if (position != '1) position++;
      if (beat.frame_end) begin
        if (scan_phase != PH_DONE) begin
          rpt = '0;
          rpt.picture_type = PIC_UNKNOWN;
          emitted = 1'b1;
        end
        clear();
      end
      if (emitted) expected_reports.push_back(rpt);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_report(out_beat_t got);
      out_beat_t want;
      if (expected_reports.size() == 0) begin
        $error("result beat with no expectation waiting");
        failures++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("found", 32'(want.found), 32'(got.found));
      compare_field("picture_type", 32'(want.picture_type), 32'(got.picture_type));
      compare_field("nal_kind", 32'(want.nal_kind), 32'(got.nal_kind));
      compare_field("slice_kind", 32'(want.slice_kind), 32'(got.slice_kind));
      compare_field("first_macroblock", 32'(want.first_macroblock),
                    32'(got.first_macroblock));
      compare_field("slice_offset", 32'(want.slice_offset), 32'(got.slice_offset));
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned idle_by_phase[4] = '{0, 59, 0, 8};
  int unsigned stall_by_phase[4] = '{0, 0, 59, 8};

  logic [7:0] frame_bytes[$];
  bit         code_bits[$];

  picture_type_scoreboard board = new();

  ptd_beat_if #(.payload_t(in_beat_t))  bytes_if ();
  ptd_beat_if #(.payload_t(out_beat_t)) result_if ();

  h264_picture_type_detector i_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if.sink),
    .result (result_if.source)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && bytes_if.valid && bytes_if.ready) board.note_byte(bytes_if.payload);
    if (!rst && result_if.valid && result_if.ready) board.check_report(result_if.payload);
  end

  function automatic void push_ue(longint unsigned value);
    logic [32:0] code;
    int          code_len;
    code = 33'(value + 1);
    code_len = 0;
    for (int i = 0; i < 33; i++) begin
      if (code[i]) code_len = i;
    end
    repeat (code_len) code_bits.push_back(1'b0);
    for (int i = code_len; i >= 0; i--) code_bits.push_back(code[i]);
  endfunction

  // prefix of 30 to 70 zeros, long enough from 32 zeros on to saturate the decoder
  function automatic void push_wide_code();
    int zeros;
    zeros = $urandom_range(30, 70);
    repeat (zeros) code_bits.push_back(1'b0);
    code_bits.push_back(1'b1);
    repeat (zeros) code_bits.push_back(1'($urandom_range(1)));
  endfunction

  function automatic void push_random_code(int unsigned common_hi);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) push_ue($urandom_range(common_hi));
    else if (r < 88) push_ue($urandom_range(2000));
    else if (r < 95) push_ue($urandom_range(60000, 70000));
    else push_wide_code();
  endfunction

  function automatic void flush_bits();
    logic [7:0] b;
    while (code_bits.size() % 8 != 0) code_bits.push_back(1'($urandom_range(1)));
    while (code_bits.size() != 0) begin
      b = '0;
      repeat (8) b = {b[6:0], code_bits.pop_front()};
      frame_bytes.push_back(b);
    end
  endfunction

  function automatic void add_start();
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'h01);
  endfunction

  function automatic void add_random_bytes(int unsigned count);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 35) frame_bytes.push_back(8'h00);
      else if (r < 45) frame_bytes.push_back(8'h01);
      else frame_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void slice_frame(logic [7:0] header, longint unsigned first_mb,
                                      longint unsigned st);
    add_start();
    frame_bytes.push_back(header);
    push_ue(first_mb);
    push_ue(st);
    flush_bits();
  endfunction

  function automatic void build_random_frame();
    logic [4:0]  kind;
    logic [2:0]  upper;
    int unsigned cut;
    frame_bytes.delete();
    code_bits.delete();
    if ($urandom_range(99) < 75) begin
      add_random_bytes($urandom_range(2));
      if ($urandom_range(99) < 30) begin
        kind = 5'($urandom_range(31));
        if (kind == NAL_SLICE || kind == NAL_IDR) kind = kind + 5'd1;
        upper = 3'($urandom_range(7));
        add_start();
        frame_bytes.push_back({upper, kind});
        add_random_bytes($urandom_range(3));
      end
      if ($urandom_range(99) < 25) frame_bytes.push_back(8'h00);
      add_start();
      upper = 3'($urandom_range(7));
      kind = $urandom_range(1) ? NAL_IDR : NAL_SLICE;
      frame_bytes.push_back({upper, kind});
      push_random_code(12);
      push_random_code(9);
      flush_bits();
      add_random_bytes($urandom_range(3));
      if ($urandom_range(99) < 10) begin
        cut = $urandom_range(frame_bytes.size() - 1);
        repeat (cut) void'(frame_bytes.pop_back());
      end
    end else begin
      add_random_bytes($urandom_range(1, 10));
    end
  endfunction

  task automatic send_byte(logic [7:0] data, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_if.valid <= 1'b1;
    bytes_if.payload <= '{data_byte: data, frame_end: last};
    do @(posedge clk); while (!bytes_if.ready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    frame_bytes.delete();
  endtask

  task automatic wait_for_reports(int settle);
    bytes_if.valid <= 1'b0;
    // let the monitor note the last accepted beat first
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    int sent;
    rst <= 1'b1;
    bytes_if.valid <= 1'b0;
    bytes_if.payload <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idr, plain i, history cleared after a header byte, header cut short,
    // saturated first_mb with a b slice
    slice_frame(8'h65, 0, 7);
    send_frame();
    slice_frame(8'hE1, 0, 2);
    send_frame();
    add_start();
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'h01);
    send_frame();
    add_start();
    frame_bytes.push_back(8'h45);
    frame_bytes.push_back(8'h00);
    send_frame();
    slice_frame(8'h01, 65536, 1);
    send_frame();
    wait_for_reports(4);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        build_random_frame();
        sent += frame_bytes.size();
        send_frame();
      end
      wait_for_reports(4);
    end

    wait_for_reports(8);
    if (board.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: h264_picture_type_detector.f
sv/ptd_pkg.sv
sv/ptd_beat_if.sv
sv/h264_picture_type_detector.sv
tb/h264_picture_type_detector_test.sv
